### src/segtree_pkg.sv
// Shared types and constants for the segment tree range sum unit.
// Used by segtree_node_mem, segtree_ctrl, the top level and the checker.
package segtree_pkg;

  localparam int unsigned DataW              = 32;
  localparam int unsigned OpW                = 2;
  localparam int unsigned IdxW               = 10;
  localparam int unsigned CountW             = 11;
  localparam int unsigned MaxElementsDefault = 1024;

  localparam logic [CountW-1:0] CountReset = 11'd1024;

  typedef enum logic [OpW-1:0] {
    OpLoad  = 2'd0,
    OpAdd   = 2'd1,
    OpQuery = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StDecode,
    StLdRd,
    StLdDelta,
    StUpRd,
    StUpWr,
    StAddRd,
    StAddCnt,
    StAddMul,
    StAddWr,
    StQTop,
    StQLacc,
    StQRchk,
    StQRacc,
    StQOut
  } state_e;

  typedef struct packed {
    logic re;
    logic we;
  } mem_cmd_t;

endpackage

### src/segtree_node_mem.sv
// Node sum memory: one synchronous port, registered read data.
// Depends on segtree_pkg for the command struct and data width.
module segtree_node_mem #(
  parameter int unsigned MaxElements = segtree_pkg::MaxElementsDefault,
  parameter int unsigned AddrW       = $clog2(2 * MaxElements)
) (
  input  logic                             clk_i,
  input  segtree_pkg::mem_cmd_t            cmd_i,
  input  logic [AddrW-1:0]                 addr_i,
  input  logic [segtree_pkg::DataW-1:0]    wdata_i,
  output logic [segtree_pkg::DataW-1:0]    rdata_o
);

  localparam int unsigned Depth = 2 * MaxElements;

  logic [segtree_pkg::DataW-1:0] mem_q [Depth];
  logic [segtree_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (cmd_i.re) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/segtree_ctrl.sv
// Sequencer for the segment tree: clear sweep, load, range add and range query.
// Depends on segtree_pkg; drives segtree_node_mem through one read-modify-write port.
module segtree_ctrl #(
  parameter int unsigned MaxElements = segtree_pkg::MaxElementsDefault,
  parameter int unsigned AddrW       = $clog2(2 * MaxElements)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [segtree_pkg::CountW-1:0]      count_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [segtree_pkg::OpW-1:0]         operation_i,
  input  logic [segtree_pkg::IdxW-1:0]        left_index_i,
  input  logic [segtree_pkg::IdxW-1:0]        right_index_i,
  input  logic [segtree_pkg::DataW-1:0]       value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [segtree_pkg::DataW-1:0]       range_sum_o,
  output segtree_pkg::mem_cmd_t               mem_cmd_o,
  output logic [AddrW-1:0]                    mem_addr_o,
  output logic [segtree_pkg::DataW-1:0]       mem_wdata_o,
  input  logic [segtree_pkg::DataW-1:0]       mem_rdata_i
);

  localparam int unsigned NW = AddrW + 1;
  localparam int unsigned LW = (AddrW > 1) ? $clog2(AddrW) : 1;
  localparam int unsigned DW = segtree_pkg::DataW;
  localparam logic [31:0] MaxE = 32'(MaxElements);
  localparam logic [AddrW-1:0] ClrLast = AddrW'(2 * MaxElements - 1);

  segtree_pkg::state_e state_q, state_d;

  segtree_pkg::op_e  op_q;
  logic [segtree_pkg::IdxW-1:0] lo_q, hi_q;
  logic [DW-1:0]     val_q;
  logic [AddrW-1:0]  a_q, a_d, b_q, b_d, k_q, k_d, lb_q, lb_d, hb_q, hb_d, clr_q, clr_d;
  logic [LW-1:0]     d_q, d_d;
  logic [NW-1:0]     l_q, l_d, r_q, r_d, ovl_q, ovl_d;
  logic [DW-1:0]     prod_q, prod_d, sum_q, sum_d;
  logic              out_valid_q, out_valid_d;
  logic [DW-1:0]     range_sum_q;
  logic              out_load;

  logic [31:0]       n32, lo32, hi32, hic32, a32, b32, b32p1;
  logic              empty;
  logic [AddrW-1:0]  start_w, hb_w, lb_w, bsh, ash, bnext, anext;
  logic [NW-1:0]     end_w, rm1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= segtree_pkg::StClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q  <= segtree_pkg::op_e'(operation_i);
      lo_q  <= left_index_i;
      hi_q  <= right_index_i;
      val_q <= value_i;
    end
    a_q    <= a_d;
    b_q    <= b_d;
    k_q    <= k_d;
    d_q    <= d_d;
    l_q    <= l_d;
    r_q    <= r_d;
    lb_q   <= lb_d;
    hb_q   <= hb_d;
    ovl_q  <= ovl_d;
    prod_q <= prod_d;
    sum_q  <= sum_d;
    if (out_load) begin
      range_sum_q <= sum_q;
    end
  end

  // range decode
  always_comb begin
    n32   = ({21'b0, count_i} > MaxE) ? MaxE : {21'b0, count_i};
    lo32  = {22'b0, lo_q};
    hi32  = {22'b0, hi_q};
    hic32 = (hi32 > n32 - 32'd1) ? n32 - 32'd1 : hi32;
    empty = (n32 == 32'd0) || (lo32 > hic32);
    a32   = MaxE + lo32;
    b32   = MaxE + hic32;
    b32p1 = b32 + 32'd1;
  end

  // node span arithmetic for range add and query stepping
  always_comb begin
    start_w = k_q << d_q;
    end_w   = {1'b0, start_w} + ((NW'(1) << d_q) - NW'(1));
    lb_w    = (a_q > start_w) ? a_q : start_w;
    hb_w    = ({1'b0, b_q} < end_w) ? b_q : end_w[AddrW-1:0];
    bsh     = b_q >> d_q;
    ash     = a_q >> d_q;
    bnext   = bsh >> 1;
    anext   = ash >> 1;
    rm1     = r_q - NW'(1);
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    a_d         = a_q;
    b_d         = b_q;
    k_d         = k_q;
    d_d         = d_q;
    l_d         = l_q;
    r_d         = r_q;
    lb_d        = lb_q;
    hb_d        = hb_q;
    ovl_d       = ovl_q;
    prod_d      = prod_q;
    sum_d       = sum_q;
    out_load    = 1'b0;
    in_ready_o  = 1'b0;
    mem_cmd_o   = '0;
    mem_addr_o  = k_q;
    mem_wdata_o = mem_rdata_i + prod_q;

    unique case (state_q)
      segtree_pkg::StClear: begin
        mem_cmd_o.we = 1'b1;
        mem_addr_o   = clr_q;
        mem_wdata_o  = '0;
        clr_d        = clr_q + AddrW'(1);
        if (clr_q == ClrLast) begin
          state_d = segtree_pkg::StIdle;
        end
      end
      segtree_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = segtree_pkg::StDecode;
        end
      end
      segtree_pkg::StDecode: begin
        a_d     = a32[AddrW-1:0];
        b_d     = b32[AddrW-1:0];
        k_d     = a32[AddrW-1:0];
        d_d     = '0;
        l_d     = a32[NW-1:0];
        r_d     = b32p1[NW-1:0];
        sum_d   = '0;
        state_d = segtree_pkg::StIdle;
        unique case (op_q)
          segtree_pkg::OpLoad: begin
            if (lo32 < n32) begin
              state_d = segtree_pkg::StLdRd;
            end
          end
          segtree_pkg::OpAdd: begin
            if (!empty) begin
              state_d = segtree_pkg::StAddRd;
            end
          end
          segtree_pkg::OpQuery: begin
            state_d = empty ? segtree_pkg::StQOut : segtree_pkg::StQTop;
          end
          default: state_d = segtree_pkg::StIdle;
        endcase
      end
      segtree_pkg::StLdRd: begin
        mem_cmd_o.re = 1'b1;
        state_d      = segtree_pkg::StLdDelta;
      end
      segtree_pkg::StLdDelta: begin
        prod_d  = val_q - mem_rdata_i;
        state_d = segtree_pkg::StUpRd;
      end
      segtree_pkg::StUpRd: begin
        mem_cmd_o.re = 1'b1;
        state_d      = segtree_pkg::StUpWr;
      end
      segtree_pkg::StUpWr: begin
        mem_cmd_o.we = 1'b1;
        k_d          = k_q >> 1;
        state_d      = (k_q == AddrW'(1)) ? segtree_pkg::StIdle : segtree_pkg::StUpRd;
      end
      segtree_pkg::StAddRd: begin
        mem_cmd_o.re = 1'b1;
        lb_d         = lb_w;
        hb_d         = hb_w;
        state_d      = segtree_pkg::StAddCnt;
      end
      segtree_pkg::StAddCnt: begin
        ovl_d   = {1'b0, hb_q} - {1'b0, lb_q} + NW'(1);
        state_d = segtree_pkg::StAddMul;
      end
      segtree_pkg::StAddMul: begin
        prod_d  = val_q * DW'(ovl_q);
        state_d = segtree_pkg::StAddWr;
      end
      segtree_pkg::StAddWr: begin
        mem_cmd_o.we = 1'b1;
        if (k_q != bsh) begin
          k_d     = k_q + AddrW'(1);
          state_d = segtree_pkg::StAddRd;
        end else if (bnext == '0) begin
          state_d = segtree_pkg::StIdle;
        end else begin
          d_d     = d_q + LW'(1);
          k_d     = (anext == '0) ? AddrW'(1) : anext;
          state_d = segtree_pkg::StAddRd;
        end
      end
      segtree_pkg::StQTop: begin
        if (l_q < r_q) begin
          if (l_q[0]) begin
            mem_cmd_o.re = 1'b1;
            mem_addr_o   = l_q[AddrW-1:0];
            l_d          = l_q + NW'(1);
            state_d      = segtree_pkg::StQLacc;
          end else begin
            state_d = segtree_pkg::StQRchk;
          end
        end else begin
          state_d = segtree_pkg::StQOut;
        end
      end
      segtree_pkg::StQLacc: begin
        sum_d   = sum_q + mem_rdata_i;
        state_d = segtree_pkg::StQRchk;
      end
      segtree_pkg::StQRchk: begin
        if (r_q[0]) begin
          mem_cmd_o.re = 1'b1;
          mem_addr_o   = rm1[AddrW-1:0];
          r_d          = rm1;
          state_d      = segtree_pkg::StQRacc;
        end else begin
          l_d     = l_q >> 1;
          r_d     = r_q >> 1;
          state_d = segtree_pkg::StQTop;
        end
      end
      segtree_pkg::StQRacc: begin
        sum_d   = sum_q + mem_rdata_i;
        l_d     = l_q >> 1;
        r_d     = r_q >> 1;
        state_d = segtree_pkg::StQTop;
      end
      segtree_pkg::StQOut: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = segtree_pkg::StIdle;
        end
      end
      default: state_d = segtree_pkg::StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign range_sum_o = range_sum_q;

endmodule

### src/segment_tree_range_sum_unit.sv
// Segment tree range sum unit: top level with the element count register.
// Depends on segtree_pkg, segtree_ctrl and segtree_node_mem.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one beat: operation, left and
//   right index, value. Load sets one element, add adds value over a range,
//   query returns the wrapping range sum on the output channel
//   (out_valid_o/out_ready_i). Other operations give no output beat.
//   Items are handled one at a time; in_ready_o is high only while idle.
//   Each item is worked through the one read-modify-write port of the node memory:
//     load  : reads the leaf for the delta, then reads and writes each node up to the root
//     query : reads at most two nodes per tree level (11 levels at 1024 elements)
//     add   : per touched node, reads it, counts the overlap, scales value, writes back
//   A query result sits in an output register; the next item is accepted
//   while it waits. If the receiver stalls, the following query holds in
//   its final state until the register frees.
//   Reset: the count register returns to 1024 and the node memory is
//   cleared by a sweep over all 2 * MaxElements nodes, in_ready_o low meanwhile.
//   The count may be written at any time through cfg_we_i/cfg_wdata_i.
module segment_tree_range_sum_unit #(
  parameter int unsigned MaxElements = segtree_pkg::MaxElementsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [segtree_pkg::CountW-1:0]       cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [segtree_pkg::OpW-1:0]          operation_i,
  input  logic [segtree_pkg::IdxW-1:0]         left_index_i,
  input  logic [segtree_pkg::IdxW-1:0]         right_index_i,
  input  logic signed [segtree_pkg::DataW-1:0] value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [segtree_pkg::DataW-1:0] range_sum_o
);

  localparam int unsigned AddrW = $clog2(2 * MaxElements);

  logic [segtree_pkg::CountW-1:0] count_q;
  segtree_pkg::mem_cmd_t          mem_cmd;
  logic [AddrW-1:0]               mem_addr;
  logic [segtree_pkg::DataW-1:0]  mem_wdata, mem_rdata, sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= segtree_pkg::CountReset;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  segtree_ctrl #(
    .MaxElements (MaxElements),
    .AddrW       (AddrW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .count_i       (count_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .left_index_i  (left_index_i),
    .right_index_i (right_index_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .range_sum_o   (sum),
    .mem_cmd_o     (mem_cmd),
    .mem_addr_o    (mem_addr),
    .mem_wdata_o   (mem_wdata),
    .mem_rdata_i   (mem_rdata)
  );

  segtree_node_mem #(
    .MaxElements (MaxElements),
    .AddrW       (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .cmd_i   (mem_cmd),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign range_sum_o = sum;

endmodule

### src/segtree_checker.sv
// Port-level checker for segment_tree_range_sum_unit, attached by bind.
// Depends on segtree_pkg for field widths.
module segtree_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic signed [segtree_pkg::DataW-1:0] range_sum_o
);

  // hold a stalled result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(range_sum_o))
    else $error("result beat changed while stalled");

  // one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while busy");

  // no result directly after an accepted beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after accept");

  // clear sweep blocks input, no stale result after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !in_ready_o && !out_valid_o)
    else $error("busy or valid right after reset");

endmodule

bind segment_tree_range_sum_unit segtree_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .range_sum_o (range_sum_o)
);

### bench/segment_tree_range_sum_unit_tb.sv
// Testbench for segment_tree_range_sum_unit: loads, range adds and range-sum queries
// are checked against a flat shadow copy of the element array.
// Depends on segtree_pkg and the segment_tree_range_sum_unit RTL.
module segment_tree_range_sum_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DataW        = segtree_pkg::DataW;
  localparam int unsigned OpW          = segtree_pkg::OpW;
  localparam int unsigned IdxW         = segtree_pkg::IdxW;
  localparam int unsigned CountW       = segtree_pkg::CountW;
  localparam int unsigned Elements     = segtree_pkg::MaxElementsDefault;
  localparam int unsigned SettleCycles = 2300;
  localparam int unsigned DrainLimit   = 20000;
  localparam int unsigned PhaseItems   = 155;
  localparam logic [OpW-1:0] OpUnused  = 2'd3;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CountW-1:0]       cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [OpW-1:0]          operation_i;
  logic [IdxW-1:0]         left_index_i;
  logic [IdxW-1:0]         right_index_i;
  logic signed [DataW-1:0] value_i;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [DataW-1:0] range_sum_o;

  logic [DataW-1:0]  element_vals [Elements];
  logic [CountW-1:0] count_shadow;
  logic [DataW-1:0]  queued_sums [$];

  int unsigned burst_left;
  int unsigned fail_count;
  int unsigned sums_checked;
  int unsigned settings_used;
  int unsigned loads_sent, adds_sent, queries_sent, unused_sent;

  logic [31:0] ready_pattern = '1;
  logic [4:0]  ready_phase   = '0;
  logic [DataW-1:0] want_sum;

  segment_tree_range_sum_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .left_index_i (left_index_i),
    .right_index_i(right_index_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .range_sum_o  (range_sum_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (ready_phase == '0) begin
      ready_pattern <= ($urandom_range(0, 3) == 0) ? '1 : ($urandom | 32'h0101_0101);
    end
    out_ready_i <= ready_pattern[ready_phase];
    ready_phase <= ready_phase + 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (queued_sums.size() == 0) begin
        if (fail_count < 10) begin
          $display("unexpected range_sum beat at %0t: got %h", $time, range_sum_o);
        end
        fail_count++;
      end else begin
        want_sum = queued_sums.pop_front();
        sums_checked++;
        if (range_sum_o !== want_sum) begin
          if (fail_count < 10) begin
            $display("range_sum mismatch at %0t: expected %h (%0d) got %h (%0d)", $time,
                     want_sum, $signed(want_sum), range_sum_o, range_sum_o);
          end
          fail_count++;
        end
      end
    end
  end

  function automatic int unsigned active_count();
    return (count_shadow > Elements) ? Elements : int'(count_shadow);
  endfunction

  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return '0;
      4, 5:    return $urandom_range(0, 200) - 100;
      default: return $urandom;
    endcase
  endfunction

  task automatic apply_to_elements(input logic [OpW-1:0] op, input logic [IdxW-1:0] lo,
                                   input logic [IdxW-1:0] hi_in, input logic [DataW-1:0] v);
    int unsigned n, hi;
    logic [DataW-1:0] sum;
    n   = active_count();
    hi  = (n == 0) ? 0 : ((hi_in > n - 1) ? n - 1 : hi_in);
    sum = '0;
    case (op)
      segtree_pkg::OpLoad: begin
        loads_sent++;
        if (lo < n) element_vals[lo] = v;
      end
      segtree_pkg::OpAdd: begin
        adds_sent++;
        if (n != 0) begin
          for (int unsigned i = lo; i <= hi; i++) element_vals[i] += v;
        end
      end
      segtree_pkg::OpQuery: begin
        queries_sent++;
        if (n != 0) begin
          for (int unsigned i = lo; i <= hi; i++) sum += element_vals[i];
        end
        queued_sums.push_back(sum);
      end
      default: unused_sent++;
    endcase
  endtask

  task automatic send_item(input logic [OpW-1:0] op, input logic [IdxW-1:0] lo,
                           input logic [IdxW-1:0] hi, input logic [DataW-1:0] v);
    int unsigned gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) gap = 0;
      else if ($urandom_range(0, 4) == 0) gap = $urandom_range(20, 60);
      else gap = $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    left_index_i  <= lo;
    right_index_i <= hi;
    value_i       <= v;
    do @(posedge clk_i); while (!in_ready_o);
    apply_to_elements(op, lo, hi, v);
  endtask

  // drain pending sums, then let any trailing add finish
  task automatic settle_block();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (queued_sums.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_count(input logic [CountW-1:0] c);
    settle_block();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= c;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    count_shadow  = c;
    settings_used++;
  endtask

  task automatic test_cleared_after_reset();
    send_item(segtree_pkg::OpQuery, 10'd0, 10'd1023, pick_value());
    send_item(segtree_pkg::OpQuery, 10'd1023, 10'd1023, pick_value());
  endtask

  task automatic test_load_and_query_extremes();
    send_item(segtree_pkg::OpLoad, 10'd0, 10'd0, 32'h7FFF_FFFF);
    send_item(segtree_pkg::OpLoad, 10'd1023, 10'd0, 32'h8000_0000);
    send_item(segtree_pkg::OpLoad, 10'd512, 10'd1023, 32'hFFFF_FFFF);
    send_item(segtree_pkg::OpQuery, 10'd0, 10'd1023, '0);
    send_item(segtree_pkg::OpQuery, 10'd0, 10'd0, '0);
    send_item(segtree_pkg::OpLoad, 10'd1023, 10'd0, 32'd5);
    send_item(segtree_pkg::OpQuery, 10'd1000, 10'd1023, '1);
    send_item(segtree_pkg::OpQuery, 10'd10, 10'd3, '0);
  endtask

  task automatic test_range_add();
    send_item(segtree_pkg::OpAdd, 10'd0, 10'd1023, 32'd1);
    send_item(segtree_pkg::OpAdd, 10'd5, 10'd5, 32'h8000_0000);
    send_item(segtree_pkg::OpAdd, 10'd9, 10'd2, 32'd77);
    send_item(OpUnused, 10'd3, 10'd900, 32'hDEAD_BEEF);
    send_item(segtree_pkg::OpQuery, 10'd0, 10'd1023, '0);
    send_item(segtree_pkg::OpQuery, 10'd4, 10'd6, '0);
  endtask

  task automatic test_count_special_cases();
    set_count(11'd0);
    send_item(segtree_pkg::OpLoad, 10'd0, 10'd0, 32'd9);
    send_item(segtree_pkg::OpAdd, 10'd0, 10'd1023, 32'd3);
    send_item(segtree_pkg::OpQuery, 10'd0, 10'd1023, '0);
    set_count(11'd5);
    send_item(segtree_pkg::OpLoad, 10'd7, 10'd0, 32'd1234);
    send_item(segtree_pkg::OpAdd, 10'd0, 10'd1023, 32'd2);
    send_item(segtree_pkg::OpQuery, 10'd3, 10'd1023, '0);
    send_item(segtree_pkg::OpQuery, 10'd6, 10'd9, '0);
    set_count(11'd1);
    send_item(segtree_pkg::OpAdd, 10'd0, 10'd0, 32'hFFFF_FFFF);
    send_item(segtree_pkg::OpQuery, 10'd0, 10'd1023, '0);
    set_count(11'd2047);
    send_item(segtree_pkg::OpAdd, 10'd1000, 10'd1023, 32'd11);
    send_item(segtree_pkg::OpQuery, 10'd1020, 10'd1023, '0);
    set_count(11'd1025);
    send_item(segtree_pkg::OpQuery, 10'd0, 10'd1023, '0);
    set_count(11'd1024);
    send_item(segtree_pkg::OpQuery, 10'd5, 10'd10, '0);
  endtask

  task automatic send_random_item(input int unsigned n, output bit counted);
    int unsigned pick, lo, hi, span;
    logic [OpW-1:0] op;
    pick = $urandom_range(0, 99);
    lo   = $urandom_range(0, n - 1);
    hi   = $urandom_range(0, Elements - 1);
    if (pick < 30) begin
      op = segtree_pkg::OpLoad;
      if ($urandom_range(0, 9) == 0) lo = $urandom_range(0, Elements - 1);
    end else if (pick < 55) begin
      op = segtree_pkg::OpAdd;
      case ($urandom_range(0, 9))
        0, 1: begin
          span = (n > 40) ? 40 : n - 1;
          lo   = n - 1 - $urandom_range(0, span);
        end
        2: hi = (lo > 0) ? $urandom_range(0, lo - 1) : 0;
        default: begin
          hi = lo + $urandom_range(0, 48);
          if (hi > Elements - 1) hi = Elements - 1;
        end
      endcase
    end else if (pick < 95) begin
      op = segtree_pkg::OpQuery;
      if ($urandom_range(0, 1) == 0) hi = lo + $urandom_range(0, Elements - 1 - lo);
      else lo = $urandom_range(0, Elements - 1);
    end else begin
      op = OpUnused;
      lo = $urandom_range(0, Elements - 1);
    end
    counted = !(op == OpUnused || (op == segtree_pkg::OpLoad && lo >= n));
    send_item(op, IdxW'(lo), IdxW'(hi), pick_value());
  endtask

  task automatic test_random_traffic();
    int unsigned done_items;
    logic [CountW-1:0] c;
    bit counted;
    for (int unsigned phase = 0; phase < 12; phase++) begin
      case (phase)
        0:       c = 11'd1024;
        1:       c = 11'd1;
        2:       c = 11'd2047;
        3:       c = 11'd2;
        4:       c = 11'd1023;
        5:       c = 11'd1025;
        default: c = CountW'($urandom_range(1, Elements));
      endcase
      set_count(c);
      done_items = 0;
      while (done_items < PhaseItems) begin
        send_random_item(active_count(), counted);
        if (counted) done_items++;
      end
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    operation_i   <= segtree_pkg::OpLoad;
    left_index_i  <= '0;
    right_index_i <= '0;
    value_i       <= '0;
    count_shadow   = segtree_pkg::CountReset;
    foreach (element_vals[i]) element_vals[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_cleared_after_reset();
    test_load_and_query_extremes();
    test_range_add();
    test_count_special_cases();
    test_random_traffic();
    settle_block();

    if (queued_sums.size() != 0) begin
      $display("%0d range sums never arrived", queued_sums.size());
      fail_count++;
    end
    $display("ran %0d loads, %0d range adds, %0d queries, %0d unused beats over %0d counts",
             loads_sent, adds_sent, queries_sent, unused_sent, settings_used);
    $display("checked %0d range sums, %0d failures", sums_checked, fail_count);
    if (fail_count == 0) begin
      $display("segment_tree_range_sum_unit_tb: PASS");
    end else begin
      $display("segment_tree_range_sum_unit_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #(30_000_000);
    $display("timeout at %0t", $time);
    $display("segment_tree_range_sum_unit_tb: FAIL");
    $finish;
  end

endmodule
